@@ rtl/jcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_pkg: shared types and constants of the JSONC comment stripper
// Character codes, lexical modes and the result flag group.
// ----------------------------------------------------------------------------
package jcs_pkg;

	localparam int CHAR_BITS_DEF = 16;
	localparam int OUT_DEPTH     = 4;

	localparam logic [7:0] U_QUOTE     = 8'h22;
	localparam logic [7:0] U_BACKSLASH = 8'h5C;
	localparam logic [7:0] U_SLASH     = 8'h2F;
	localparam logic [7:0] U_STAR      = 8'h2A;
	localparam logic [7:0] U_LF        = 8'h0A;
	localparam logic [7:0] U_CR        = 8'h0D;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_LINE   = 2'd1,
		MODE_BLOCK  = 2'd2
	} mode_t;

	typedef struct packed {
		logic kept;
		logic last;
	} res_flags_t;

endpackage

@@ rtl/jcs_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_lexer: lexical state and per-character result generation
// Updates comment/string state for one character and forms up to two results.
// ----------------------------------------------------------------------------
module jcs_lexer #(
	parameter int CHAR_BITS = jcs_pkg::CHAR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [CHAR_BITS-1:0]  in_char,
	input  logic                  in_last,
	output logic [CHAR_BITS-1:0]  r0_char,
	output jcs_pkg::res_flags_t   r0_flags,
	output logic [CHAR_BITS-1:0]  r1_char,
	output jcs_pkg::res_flags_t   r1_flags,
	output logic                  two_res
);

	localparam logic [CHAR_BITS-1:0] C_QUOTE = CHAR_BITS'(jcs_pkg::U_QUOTE);
	localparam logic [CHAR_BITS-1:0] C_BSL   = CHAR_BITS'(jcs_pkg::U_BACKSLASH);
	localparam logic [CHAR_BITS-1:0] C_SLASH = CHAR_BITS'(jcs_pkg::U_SLASH);
	localparam logic [CHAR_BITS-1:0] C_STAR  = CHAR_BITS'(jcs_pkg::U_STAR);
	localparam logic [CHAR_BITS-1:0] C_LF    = CHAR_BITS'(jcs_pkg::U_LF);
	localparam logic [CHAR_BITS-1:0] C_CR    = CHAR_BITS'(jcs_pkg::U_CR);

	jcs_pkg::mode_t mode_q, mode_d, mode_mid;
	logic str_q, str_d;
	logic bsl_q;
	logic hslash_q, hslash_d;
	logic hstar_q, hstar_d;
	logic consumed, emit_slash, emit_char, emit_tail;

	always_comb begin
		mode_mid   = mode_q;
		consumed   = 1'b0;
		emit_slash = 1'b0;
		emit_char  = 1'b0;
		hslash_d   = 1'b0;
		hstar_d    = 1'b0;
		str_d      = str_q;
		if (hslash_q) begin
			if (in_char == C_SLASH) begin
				mode_mid = jcs_pkg::MODE_LINE;
				consumed = 1'b1;
			end else if (in_char == C_STAR) begin
				mode_mid = jcs_pkg::MODE_BLOCK;
				consumed = 1'b1;
			end else begin
				emit_slash = 1'b1;
			end
		end else if (hstar_q) begin
			if (in_char == C_SLASH) begin
				mode_mid = jcs_pkg::MODE_NORMAL;
				consumed = 1'b1;
			end
		end
		mode_d = mode_mid;
		if (!consumed) begin
			case (mode_mid)
				jcs_pkg::MODE_LINE: begin
					if (in_char == C_LF || in_char == C_CR) begin
						mode_d    = jcs_pkg::MODE_NORMAL;
						emit_char = 1'b1;
					end
				end
				jcs_pkg::MODE_BLOCK: begin
					hstar_d = (in_char == C_STAR);
				end
				default: begin
					if (in_char == C_QUOTE && !bsl_q)
						str_d = !str_q;
					if (!str_d && in_char == C_SLASH)
						hslash_d = 1'b1;
					else
						emit_char = 1'b1;
				end
			endcase
		end
		emit_tail = in_last && hslash_d;
	end

	// pack the results in order: held slash, character, trailing slash
	always_comb begin
		r0_char  = '0;
		r0_flags = '0;
		r1_char  = '0;
		r1_flags = '0;
		two_res  = 1'b0;
		if (emit_slash) begin
			r0_char       = C_SLASH;
			r0_flags.kept = 1'b1;
			if (emit_char) begin
				r1_char       = in_char;
				r1_flags.kept = 1'b1;
				two_res       = 1'b1;
			end
		end else if (emit_char) begin
			r0_char       = in_char;
			r0_flags.kept = 1'b1;
		end else if (emit_tail) begin
			r0_char       = C_SLASH;
			r0_flags.kept = 1'b1;
		end
		if (in_last) begin
			if (two_res)
				r1_flags.last = 1'b1;
			else
				r0_flags.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= jcs_pkg::MODE_NORMAL;
			str_q    <= 1'b0;
			bsl_q    <= 1'b0;
			hslash_q <= 1'b0;
			hstar_q  <= 1'b0;
		end else if (step) begin
			if (in_last) begin
				mode_q   <= jcs_pkg::MODE_NORMAL;
				str_q    <= 1'b0;
				bsl_q    <= 1'b0;
				hslash_q <= 1'b0;
				hstar_q  <= 1'b0;
			end else begin
				mode_q   <= mode_d;
				str_q    <= str_d;
				bsl_q    <= (in_char == C_BSL);
				hslash_q <= hslash_d;
				hstar_q  <= hstar_d;
			end
		end
	end

endmodule

@@ rtl/jcs_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_out_fifo: result queue
// Takes up to two results per cycle and presents one per cycle to the sink while it is ready.
// ----------------------------------------------------------------------------
module jcs_out_fifo #(
	parameter int CHAR_BITS = jcs_pkg::CHAR_BITS_DEF,
	parameter int DEPTH     = jcs_pkg::OUT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 push_two,
	input  logic [CHAR_BITS-1:0] w0_char,
	input  jcs_pkg::res_flags_t  w0_flags,
	input  logic [CHAR_BITS-1:0] w1_char,
	input  jcs_pkg::res_flags_t  w1_flags,
	output logic                 room_two,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output logic [CHAR_BITS-1:0] rd_char,
	output jcs_pkg::res_flags_t  rd_flags
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CHAR_BITS-1:0] char_q  [DEPTH];
	jcs_pkg::res_flags_t  flags_q [DEPTH];
	logic [PW-1:0]        wr_q, rd_q, wr_next;
	logic [CW-1:0]        cnt_q;
	logic                 pop;

	assign pop      = rd_valid && rd_ready;
	assign rd_valid = (cnt_q != '0);
	assign room_two = (cnt_q <= CW'(DEPTH - 2));
	assign rd_char  = char_q[rd_q];
	assign rd_flags = flags_q[rd_q];
	assign wr_next  = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push) begin
			char_q[wr_q]  <= w0_char;
			flags_q[wr_q] <= w0_flags;
			if (push_two) begin
				char_q[wr_next]  <= w1_char;
				flags_q[wr_next] <= w1_flags;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				if (push_two)
					wr_q <= (wr_next == PW'(DEPTH - 1)) ? '0 : wr_next + 1'b1;
				else
					wr_q <= wr_next;
			end
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? (push_two ? CW'(2) : CW'(1)) : CW'(0))
				- (pop ? CW'(1) : CW'(0));
		end
	end

endmodule

@@ rtl/jsonc_comment_stripper_top.sv @@
`timescale 1ns / 1ps
// An accepted input is registered in the input stage, then in the result queue.
// Throughput: one character per cycle while the result queue has room for two
// results; one character can yield two (a released slash plus the character).
// The 4-entry result queue sets the rate under backpressure.
// Reset: arst_n clears all lexical state and empties the input stage and queue.
// ----------------------------------------------------------------------------
// jsonc_comment_stripper_top: JSON-with-comments comment remover
// Streams characters in, drops line and block comments, streams kept ones out.
// ----------------------------------------------------------------------------
module jsonc_comment_stripper_top #(
	parameter int CHAR_BITS = jcs_pkg::CHAR_BITS_DEF,
	localparam int DW = ((CHAR_BITS + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // in_char
	input  logic          s_tlast,   // in_last
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata,   // out_char
	output logic          m_tuser,   // out_valid
	output logic          m_tlast    // out_last
);

	logic                 v_s1;
	logic [CHAR_BITS-1:0] char_s1;
	logic                 last_s1;
	logic                 fire;
	logic                 room_two;
	logic [CHAR_BITS-1:0] r0_char, r1_char, rd_char;
	jcs_pkg::res_flags_t  r0_flags, r1_flags, rd_flags;
	logic                 two_res;

	assign fire     = v_s1 && room_two;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[CHAR_BITS-1:0];
			last_s1 <= s_tlast;
		end
	end

	jcs_lexer #(
		.CHAR_BITS(CHAR_BITS)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire),
		.in_char (char_s1),
		.in_last (last_s1),
		.r0_char (r0_char),
		.r0_flags(r0_flags),
		.r1_char (r1_char),
		.r1_flags(r1_flags),
		.two_res (two_res)
	);

	jcs_out_fifo #(
		.CHAR_BITS(CHAR_BITS),
		.DEPTH    (jcs_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fire && (r0_flags.kept || r0_flags.last)),
		.push_two(two_res),
		.w0_char (r0_char),
		.w0_flags(r0_flags),
		.w1_char (r1_char),
		.w1_flags(r1_flags),
		.room_two(room_two),
		.rd_valid(m_tvalid),
		.rd_ready(m_tready),
		.rd_char (rd_char),
		.rd_flags(rd_flags)
	);

	assign m_tdata = DW'(rd_char);
	assign m_tuser = rd_flags.kept;
	assign m_tlast = rd_flags.last;

endmodule
